/* src/fcvf_pkg.sv */
package fcvf_pkg;

  localparam int LevelW    = 32;
  localparam int CountW    = 13;
  localparam int MagW      = 12;
  localparam int NumCh     = 4;
  localparam int ChW       = 2;
  localparam int OutW      = 8;
  localparam int OutLsb    = 12;
  localparam int FramesW   = 16;
  localparam int CfgIdxW   = 2;
  localparam int FadeLimit = 4095;

  // func field codes
  localparam logic FuncStart = 1'b0;
  localparam logic FuncTick  = 1'b1;

  typedef logic [LevelW-1:0] level_t;
  typedef logic [MagW-1:0]   mag_t;

  // clamp a signed frame count to the fade range
  function automatic logic [CountW-1:0] sat_frames(input logic signed [FramesW-1:0] f);
    logic signed [FramesW-1:0] hi;
    logic signed [FramesW-1:0] lo;
    hi = FramesW'(FadeLimit);
    lo = -FramesW'(FadeLimit);
    if (f > hi) begin
      sat_frames = CountW'(FadeLimit);
    end else if (f < lo) begin
      sat_frames = -CountW'(FadeLimit);
    end else begin
      sat_frames = f[CountW-1:0];
    end
  endfunction

endpackage

/* src/four_channel_volume_fade.sv */
// channel  | handshake                   | payload
// ---------+-----------------------------+-------------------------------------
// input    | in_valid_i / in_stall_o     | func_i, frames_i
// output   | out_valid_o / out_stall_i   | out_ll_o, out_lr_o, out_rr_o, out_rl_o
// config   | cfg_we_i                    | cfg_idx_i, cfg_data_i
//
// a start transaction gives no result
// a tick with a nonzero count passes each of the four levels in turn through the
// bit-serial multiplier and the shared restoring divider; a tick with a zero count
// goes straight to the done step
// reset clears the count, the levels and the full levels
// the input is stalled while a tick is at work; a waiting result is held in the
// output register, and a new transaction is taken while it waits
module four_channel_volume_fade import fcvf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      func_i,
  input  logic signed [FramesW-1:0] frames_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [OutW-1:0]           out_ll_o,
  output logic [OutW-1:0]           out_lr_o,
  output logic [OutW-1:0]           out_rr_o,
  output logic [OutW-1:0]           out_rl_o,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  level_t                    cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StDiv,
    StDone
  } state_e;

  state_e            state_q;
  logic [CountW-1:0] count_q;
  logic [ChW-1:0]    ch_q;
  level_t            level_q [NumCh];
  level_t            full_q  [NumCh];
  logic              mul_start_q;
  logic              out_valid_q;
  logic [OutW-1:0]   out_q   [NumCh];

  logic              in_acc;
  logic              out_free;
  logic              fade_out;
  logic [CountW-1:0] count_neg;
  mag_t              mag;
  level_t            mcand;
  level_t            prod;
  level_t            quot;
  logic              mul_done;
  logic              div_done;
  logic              last_ch;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fade_out  = !count_q[CountW-1];
  assign count_neg = -count_q;
  assign mag       = fade_out ? count_q[MagW-1:0] : count_neg[MagW-1:0];
  assign mcand     = fade_out ? level_q[ch_q] : full_q[ch_q] - level_q[ch_q];
  assign last_ch   = ch_q == ChW'(NumCh - 1);

  fcvf_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start_q),
    .mcand_i  (mcand),
    .mplier_i (mag - 1'b1),
    .done_o   (mul_done),
    .prod_o   (prod)
  );

  fcvf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mul_done),
    .dividend_i (prod),
    .divisor_i  (mag),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      ch_q        <= '0;
      mul_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumCh; i++) begin
        level_q[i] <= '0;
        full_q[i]  <= '0;
      end
    end else begin
      mul_start_q <= 1'b0;
      // a finished result goes out as soon as the output register is free
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        full_q[cfg_idx_i] <= cfg_data_i;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (func_i == FuncStart) begin
              count_q <= sat_frames(frames_i);
            end else if (count_q == '0) begin
              state_q <= StDone;
            end else begin
              ch_q        <= '0;
              mul_start_q <= 1'b1;
              state_q     <= StMul;
            end
          end
        end
        StMul: begin
          if (mul_done) begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (div_done) begin
            level_q[ch_q] <= fade_out ? quot : full_q[ch_q] - quot;
            if (last_ch) begin
              count_q <= fade_out ? count_q - 1'b1 : count_q + 1'b1;
              state_q <= StDone;
            end else begin
              ch_q        <= ch_q + 1'b1;
              mul_start_q <= 1'b1;
              state_q     <= StMul;
            end
          end
        end
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDone && out_free) begin
      for (int i = 0; i < NumCh; i++) begin
        out_q[i] <= level_q[i][OutLsb +: OutW];
      end
    end
  end

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_valid_q;
  assign out_ll_o    = out_q[0];
  assign out_lr_o    = out_q[1];
  assign out_rr_o    = out_q[2];
  assign out_rl_o    = out_q[3];

  // multiplier and divider hand over, never finish together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mul_done && div_done))
    else $error("multiplier and divider finished in the same cycle");

  // a quotient only arrives while waiting for it
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |-> state_q == StDiv)
    else $error("divider finished outside the divide step");

  // the count is never zero while a level is being ramped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul || state_q == StDiv) |-> count_q != '0)
    else $error("ramp running with a zero count");

  // a new result only comes out of the done step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone))
    else $error("result raised outside the done step");

endmodule

/* src/fcvf_mul.sv */
module fcvf_mul import fcvf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  level_t mcand_i,
  input  mag_t   mplier_i,
  output logic   done_o,
  output level_t prod_o
);

  localparam int MulCntW = $clog2(MagW);
  localparam logic [MulCntW-1:0] MulLast = MulCntW'(MagW - 1);

  logic               busy_q;
  logic               done_q;
  logic [MulCntW-1:0] cnt_q;
  level_t             acc_q;
  level_t             mcand_q;
  mag_t               mplier_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MulLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift-add, one multiplier bit per cycle, product kept modulo 2^32
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= {mcand_q[LevelW-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[MagW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* src/fcvf_div.sv */
module fcvf_div import fcvf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  level_t dividend_i,
  input  mag_t   divisor_i,
  output logic   done_o,
  output level_t quot_o
);

  localparam int DivCntW = $clog2(LevelW);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(LevelW - 1);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  level_t             shift_q;
  mag_t               rem_q;
  mag_t               divisor_q;
  logic [MagW:0]      trial;
  logic               fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring divide: dividend bits shift out the top, quotient bits shift in
  assign trial = {rem_q, shift_q[LevelW-1]};
  assign fits  = trial >= {1'b0, divisor_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q   <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      shift_q <= {shift_q[LevelW-2:0], fits};
      if (fits) begin
        rem_q <= MagW'(trial - {1'b0, divisor_q});
      end else begin
        rem_q <= trial[MagW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = shift_q;

endmodule
